### sv/csl_pkg.sv
`timescale 1ns / 1ps

package csl_pkg;

  localparam int KEPT_CHARS = 6;
  localparam int LEN_W      = $clog2(KEPT_CHARS + 2);
  localparam int IDX_W      = $clog2(KEPT_CHARS);
  localparam int KIND_W     = 6;
  localparam int BYTE_W     = 8;

  localparam int RES_DEPTH  = 4;
  localparam int PTR_W      = $clog2(RES_DEPTH);
  localparam int CNT_W      = $clog2(RES_DEPTH + 1);

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [KEPT_CHARS-1:0][BYTE_W-1:0] lex_chars_t;

  localparam kind_t TK_ID            = 6'd0;
  localparam kind_t TK_NUMBER        = 6'd1;
  localparam kind_t TK_RESERVED      = 6'd2;
  localparam kind_t TK_OP_PLUS       = 6'd10;
  localparam kind_t TK_OP_MINUS      = 6'd11;
  localparam kind_t TK_OP_STAR       = 6'd12;
  localparam kind_t TK_OP_SLASH      = 6'd13;
  localparam kind_t TK_OP_ASSIGN     = 6'd14;
  localparam kind_t TK_OP_EQ         = 6'd15;
  localparam kind_t TK_OP_NE         = 6'd16;
  localparam kind_t TK_OP_GT         = 6'd17;
  localparam kind_t TK_OP_LT         = 6'd18;
  localparam kind_t TK_OP_GE         = 6'd19;
  localparam kind_t TK_OP_LE         = 6'd20;
  localparam kind_t TK_OPER_UNLISTED = 6'd21;
  localparam kind_t TK_DL_SEMI       = 6'd22;
  localparam kind_t TK_DL_COMMA      = 6'd23;
  localparam kind_t TK_DL_LPAREN     = 6'd24;
  localparam kind_t TK_DL_RPAREN     = 6'd25;
  localparam kind_t TK_DL_LBRACK     = 6'd26;
  localparam kind_t TK_DL_RBRACK     = 6'd27;
  localparam kind_t TK_DL_LBRACE     = 6'd28;
  localparam kind_t TK_DL_RBRACE     = 6'd29;
  localparam kind_t TK_ERROR         = 6'd30;
  localparam kind_t TK_ACCEPT        = 6'd31;
  localparam kind_t TK_REJECT        = 6'd32;

  // reserved words, space padded, first character in the top byte
  localparam int NUM_WORDS = 8;
  localparam int WORD_MAX  = 6;
  localparam logic [BYTE_W*WORD_MAX-1:0] WORD_TEXT [NUM_WORDS] = '{
    "if    ", "else  ", "while ", "for   ", "int   ", "float ", "return", "void  "
  };
  localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
    3'd2, 3'd4, 3'd5, 3'd3, 3'd3, 3'd5, 3'd6, 3'd4
  };

  typedef struct packed {
    logic blank;
    logic letter;
    logic digit;
    logic oper;
    logic delim;
  } byte_class_t;

  // results caused by one item, at most two
  typedef struct packed {
    logic [1:0] count;
    kind_t      kind0;
    kind_t      kind1;
  } lex_res_t;

  typedef struct packed {
    logic  last;
    kind_t kind;
  } res_entry_t;

  function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    c.blank  = (b == 8'h0A) || (b == 8'h09) || (b == " ");
    c.letter = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
    c.digit  = ((b >= "0") && (b <= "9")) || (b == ".");
    c.oper   = (b == "=") || (b == "+") || (b == "-") || (b == "*") ||
               (b == "/") || (b == "<") || (b == ">") || (b == "!");
    c.delim  = (b == "(") || (b == ")") || (b == "[") || (b == "]") ||
               (b == "{") || (b == "}") || (b == ";") || (b == ",");
    return c;
  endfunction

  function automatic kind_t word_code(input lex_chars_t chars, input logic [LEN_W-1:0] len);
    kind_t code;
    logic  hit;
    code = TK_ID;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      hit = (len == LEN_W'(WORD_LEN[i]));
      for (int j = 0; j < WORD_MAX; j++) begin
        if ((j < int'(WORD_LEN[i])) &&
            (chars[j] != WORD_TEXT[i][BYTE_W*(WORD_MAX-1-j) +: BYTE_W])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        code = TK_RESERVED + KIND_W'(i);
      end
    end
    return code;
  endfunction

  function automatic kind_t oper_code(input logic [BYTE_W-1:0] c0, input logic [BYTE_W-1:0] c1,
                                      input logic [LEN_W-1:0] len);
    kind_t code;
    code = TK_OPER_UNLISTED;
    if (len == LEN_W'(1)) begin
      unique case (c0)
        "+":     code = TK_OP_PLUS;
        "-":     code = TK_OP_MINUS;
        "*":     code = TK_OP_STAR;
        "/":     code = TK_OP_SLASH;
        "=":     code = TK_OP_ASSIGN;
        ">":     code = TK_OP_GT;
        "<":     code = TK_OP_LT;
        default: code = TK_OPER_UNLISTED;
      endcase
    end else if ((len == LEN_W'(2)) && (c1 == "=")) begin
      unique case (c0)
        "=":     code = TK_OP_EQ;
        "!":     code = TK_OP_NE;
        ">":     code = TK_OP_GE;
        "<":     code = TK_OP_LE;
        default: code = TK_OPER_UNLISTED;
      endcase
    end
    return code;
  endfunction

  function automatic kind_t delim_code(input logic [BYTE_W-1:0] c0);
    kind_t code;
    unique case (c0)
      ";":     code = TK_DL_SEMI;
      ",":     code = TK_DL_COMMA;
      "(":     code = TK_DL_LPAREN;
      ")":     code = TK_DL_RPAREN;
      "[":     code = TK_DL_LBRACK;
      "]":     code = TK_DL_RBRACK;
      "{":     code = TK_DL_LBRACE;
      "}":     code = TK_DL_RBRACE;
      default: code = TK_DL_SEMI;
    endcase
    return code;
  endfunction

endpackage

### sv/csl_lex.sv
`timescale 1ns / 1ps

module csl_lex (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_go,
  input  logic                      step_mode,
  input  logic [csl_pkg::BYTE_W-1:0] step_byte,
  output csl_pkg::lex_res_t         res
);

  import csl_pkg::*;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_WORD  = 6'b000010,
    PH_NUM   = 6'b000100,
    PH_OPER  = 6'b001000,
    PH_DELIM = 6'b010000,
    PH_TRAP  = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              err_r, err_nxt;
  lex_chars_t        chars_r;

  byte_class_t       cls;
  logic              chars_we;
  logic [IDX_W-1:0]  chars_idx;
  logic              start_go, push_go, trap_go;
  logic              pre_v, mid_v, fin_v;
  kind_t             pre_k, fin_k;

  assign cls = classify(step_byte);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    err_nxt   = err_r;
    chars_we  = 1'b0;
    chars_idx = len_r[IDX_W-1:0];
    start_go  = 1'b0;
    push_go   = 1'b0;
    trap_go   = 1'b0;
    pre_v     = 1'b0;
    pre_k     = TK_ID;
    mid_v     = 1'b0;
    fin_v     = 1'b0;
    fin_k     = TK_ACCEPT;
    if (step_mode) begin
      // end of text: flush delimiter, late error, then verdict
      pre_v     = (phase_r == PH_DELIM);
      pre_k     = delim_code(chars_r[0]);
      mid_v     = (phase_r == PH_TRAP) && !err_r;
      fin_v     = 1'b1;
      fin_k     = (phase_r == PH_START) ? TK_ACCEPT : TK_REJECT;
      phase_nxt = PH_START;
      len_nxt   = '0;
      err_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        PH_WORD: begin
          if (cls.blank || cls.oper || cls.delim) begin
            pre_v    = 1'b1;
            pre_k    = word_code(chars_r, len_r);
            start_go = 1'b1;
          end else if (cls.letter || cls.digit) begin
            push_go = 1'b1;
          end else begin
            trap_go = 1'b1;
          end
        end
        PH_NUM: begin
          if (cls.blank || cls.oper || cls.delim) begin
            pre_v    = 1'b1;
            pre_k    = TK_NUMBER;
            start_go = 1'b1;
          end else if (cls.letter) begin
            // error is reported with the next item
            push_go   = 1'b1;
            phase_nxt = PH_TRAP;
          end else if (cls.digit) begin
            push_go = 1'b1;
          end else begin
            trap_go = 1'b1;
          end
        end
        PH_OPER: begin
          if (cls.blank || cls.letter || cls.digit) begin
            pre_v    = 1'b1;
            pre_k    = oper_code(chars_r[0], chars_r[1], len_r);
            start_go = 1'b1;
          end else if (cls.oper) begin
            push_go = 1'b1;
            if (len_r >= LEN_W'(2)) begin
              phase_nxt = PH_TRAP;
            end
          end else begin
            trap_go = 1'b1;
          end
        end
        PH_DELIM: begin
          pre_v    = 1'b1;
          pre_k    = delim_code(chars_r[0]);
          start_go = 1'b1;
        end
        PH_TRAP: begin
          trap_go = 1'b1;
        end
        PH_START: begin
          start_go = 1'b1;
        end
        default: begin
          start_go = 1'b1;
        end
      endcase

      if (push_go) begin
        chars_we = (len_r < LEN_W'(KEPT_CHARS));
        if (len_r <= LEN_W'(KEPT_CHARS)) begin
          len_nxt = len_r + LEN_W'(1);
        end
      end

      if (start_go) begin
        len_nxt   = '0;
        chars_idx = '0;
        if (cls.blank) begin
          phase_nxt = PH_START;
        end else if (cls.letter || cls.digit || cls.oper || cls.delim) begin
          chars_we = 1'b1;
          len_nxt  = LEN_W'(1);
          if (cls.letter) begin
            phase_nxt = PH_WORD;
          end else if (cls.digit) begin
            phase_nxt = PH_NUM;
          end else if (cls.oper) begin
            phase_nxt = PH_OPER;
          end else begin
            phase_nxt = PH_DELIM;
          end
        end else begin
          trap_go = 1'b1;
        end
      end

      if (trap_go) begin
        phase_nxt = PH_TRAP;
        mid_v     = !err_r;
        err_nxt   = 1'b1;
      end
    end
  end

  // pack the up to two valid slots in order
  always_comb begin
    res.count = step_go ? (2'(pre_v) + 2'(mid_v) + 2'(fin_v)) : 2'd0;
    res.kind0 = pre_v ? pre_k : (mid_v ? TK_ERROR : fin_k);
    res.kind1 = (pre_v && mid_v) ? TK_ERROR : fin_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= '0;
      err_r   <= 1'b0;
    end else if (step_go) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && chars_we) begin
      chars_r[chars_idx] <= step_byte;
    end
  end

endmodule

### sv/csl_res_fifo.sv
`timescale 1ns / 1ps

module csl_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  csl_pkg::lex_res_t push,
  input  logic              pop,
  output csl_pkg::kind_t    head_kind,
  output logic              head_last,
  output logic              head_valid,
  output logic              room2
);

  import csl_pkg::*;

  res_entry_t        mem_r [RES_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  res_entry_t        head;

  assign head       = mem_r[rd_ptr_r];
  assign head_kind  = head.kind;
  assign head_last  = head.last;
  assign head_valid = (cnt_r != '0);
  assign room2      = (cnt_r <= CNT_W'(RES_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= '{last: (push.count == 2'd1), kind: push.kind0};
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= '{last: 1'b1, kind: push.kind1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### sv/c_subset_lexer_core.sv
`timescale 1ns / 1ps
// Lexer for a small C subset, one text byte per request.
// Input channel: in_tdata carries the text byte, in_tuser marks end of text
// (the byte is then ignored). Output channel: out_tdata[5:0] is the token
// code, out_tlast marks the final token caused by one input request.
// A request causes zero, one or two tokens: a token when a lexeme closes,
// an error once per trapped text, and at end of text an accept or reject
// verdict, after which the lexer state returns to its reset values.
// A request is held in the input register until the queue has room for two
// tokens; its tokens are then written into the queue that drives out_tvalid.
// Throughput: one request per cycle. The lexer step is one pass of logic
// between the input register and a four-entry result queue; tokens leave
// the queue at one per cycle while out_tready is high, so the two tokens of
// one request leave in turn, and input is held off only while the queue lacks
// room for two tokens.
// When the receiver stalls, tokens wait in the queue and in_tready drops
// once the input register is full and the queue cannot take two more.
// Reset (synchronous, rst_n low) empties the queue and the input register
// and returns the lexer to its start phase with no error reported.
module c_subset_lexer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] mode: 1 = end of text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] token_kind, [7:6] zero
  output logic       out_tlast
);

  import csl_pkg::*;

  logic              s_valid_r, s_valid_nxt;
  logic              s_mode_r;
  logic [BYTE_W-1:0] s_byte_r;
  logic              in_fire, step_go, room2;
  lex_res_t          res;
  kind_t             head_kind;

  assign step_go   = s_valid_r && room2;
  assign in_tready = !s_valid_r || step_go;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_fire) begin
      s_valid_nxt = 1'b1;
    end else if (step_go) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_mode_r <= in_tuser;
      s_byte_r <= in_tdata;
    end
  end

  csl_lex u_lex (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_go   (step_go),
    .step_mode (s_mode_r),
    .step_byte (s_byte_r),
    .res       (res)
  );

  csl_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res),
    .pop        (out_tvalid && out_tready),
    .head_kind  (head_kind),
    .head_last  (out_tlast),
    .head_valid (out_tvalid),
    .room2      (room2)
  );

  assign out_tdata = {{(8 - KIND_W){1'b0}}, head_kind};

  // end of text always yields at least the verdict
  a_end_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && s_mode_r |-> res.count != 2'd0)
    else $error("end of text produced no token");

  // a request waiting for queue room keeps its payload
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !step_go |=> s_valid_r && $stable(s_byte_r) && $stable(s_mode_r))
    else $error("stalled input request lost or changed");

  // no step may push more than two tokens
  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |-> res.count != 2'd3)
    else $error("lexer step pushed more than two tokens");

endmodule

### tb/tb_c_subset_lexer_core.sv
`timescale 1ns / 1ps

module tb_c_subset_lexer_core;
  import csl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_OPER, SCAN_DELIM, SCAN_TRAP
  } scan_phase_e;

  typedef enum logic [2:0] {
    CL_BLANK, CL_LETTER, CL_DIGIT, CL_OPER, CL_DELIM, CL_OTHER
  } char_class_e;

  typedef enum logic [1:0] {
    PACE_FULL, PACE_SLOW_SEND, PACE_SLOW_RECV, PACE_LIGHT
  } pace_e;

  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } text_item_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } token_t;

  localparam int HOLD_CYCLES = 300;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  c_subset_lexer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  string kw_list [8] = '{"if", "else", "while", "for", "int", "float", "return", "void"};
  string oper_words [11] = '{"+", "-", "*", "/", "=", "==", "!=", ">", "<", ">=", "<="};
  string oper_chars  = "=+-*/<>!";
  string delim_chars = ";,()[]{}";
  string num_chars   = "0123456789.";

  text_item_t text_queue [$];
  token_t     pending_tokens [$];
  kind_t      step_tokens [$];

  // lexer state as predicted
  scan_phase_e scan_phase = SCAN_IDLE;
  logic [7:0]  lex_buf [KEPT_CHARS];
  int          lex_len     = 0;
  bit          err_flagged = 1'b0;

  pace_e pace        = PACE_FULL;
  bit    stall_kick  = 1'b0;
  int    stall_left  = 0;

  int fail_count    = 0;
  int items_queued  = 0;
  int texts_queued  = 0;
  int requests_sent = 0;
  int tokens_seen   = 0;
  int n_accept      = 0;
  int n_reject      = 0;
  int n_error       = 0;

  function automatic bit roll_pct(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_idle_pct();
    case (pace)
      PACE_SLOW_SEND: return 75;
      PACE_LIGHT:     return 8;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (pace)
      PACE_SLOW_RECV: return 75;
      PACE_LIGHT:     return 8;
      default:        return 0;
    endcase
  endfunction

  function automatic char_class_e char_class(logic [7:0] b);
    if (b == 8'h0A || b == 8'h09 || b == 8'h20) return CL_BLANK;
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return CL_LETTER;
    if ((b >= "0" && b <= "9") || b == ".") return CL_DIGIT;
    for (int i = 0; i < oper_chars.len(); i++) begin
      if (b == oper_chars[i]) return CL_OPER;
    end
    for (int i = 0; i < delim_chars.len(); i++) begin
      if (b == delim_chars[i]) return CL_DELIM;
    end
    return CL_OTHER;
  endfunction

  function automatic void lex_clear();
    scan_phase  = SCAN_IDLE;
    lex_len     = 0;
    err_flagged = 1'b0;
    for (int i = 0; i < KEPT_CHARS; i++) lex_buf[i] = '0;
  endfunction

  // length saturates one past the kept characters, meaning too long
  function automatic void keep_char(logic [7:0] b);
    if (lex_len < KEPT_CHARS) lex_buf[lex_len] = b;
    if (lex_len <= KEPT_CHARS) lex_len++;
  endfunction

  function automatic bit lexeme_matches(string s);
    if (s.len() != lex_len || s.len() > KEPT_CHARS) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (lex_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic kind_t word_kind();
    for (int i = 0; i < 8; i++) begin
      if (lexeme_matches(kw_list[i])) return TK_RESERVED + kind_t'(i);
    end
    return TK_ID;
  endfunction

  function automatic kind_t oper_kind();
    for (int i = 0; i < 11; i++) begin
      if (lexeme_matches(oper_words[i])) return TK_OP_PLUS + kind_t'(i);
    end
    return TK_OPER_UNLISTED;
  endfunction

  function automatic kind_t delim_kind();
    for (int i = 0; i < delim_chars.len(); i++) begin
      if (lex_buf[0] == delim_chars[i]) return TK_DL_SEMI + kind_t'(i);
    end
    return TK_DL_SEMI;
  endfunction

  function automatic void emit_token(kind_t k);
    if (step_tokens.size() < 2) step_tokens.push_back(k);
  endfunction

  function automatic void enter_trap();
    scan_phase = SCAN_TRAP;
    if (!err_flagged) emit_token(TK_ERROR);
    err_flagged = 1'b1;
  endfunction

  function automatic void restart_lexeme(logic [7:0] b);
    lex_len = 0;
    case (char_class(b))
      CL_BLANK: scan_phase = SCAN_IDLE;
      CL_LETTER: begin
        keep_char(b);
        scan_phase = SCAN_WORD;
      end
      CL_DIGIT: begin
        keep_char(b);
        scan_phase = SCAN_NUMBER;
      end
      CL_OPER: begin
        keep_char(b);
        scan_phase = SCAN_OPER;
      end
      CL_DELIM: begin
        keep_char(b);
        scan_phase = SCAN_DELIM;
      end
      default: enter_trap();
    endcase
  endfunction

  function automatic void lex_step(logic eot, logic [7:0] b);
    char_class_e cl;
    bit          separator;
    token_t      t;
    cl = char_class(b);
    separator = (cl == CL_BLANK) || (cl == CL_OPER) || (cl == CL_DELIM);
    step_tokens.delete();
    if (eot) begin
      if (scan_phase == SCAN_DELIM) emit_token(delim_kind());
      if (scan_phase == SCAN_TRAP && !err_flagged) emit_token(TK_ERROR);
      emit_token(scan_phase == SCAN_IDLE ? TK_ACCEPT : TK_REJECT);
      lex_clear();
    end else begin
      case (scan_phase)
        SCAN_WORD: begin
          if (separator) begin
            emit_token(word_kind());
            restart_lexeme(b);
          end else if (cl == CL_LETTER || cl == CL_DIGIT) begin
            keep_char(b);
          end else begin
            enter_trap();
          end
        end
        SCAN_NUMBER: begin
          if (separator) begin
            emit_token(TK_NUMBER);
            restart_lexeme(b);
          end else if (cl == CL_LETTER) begin
            // trapped now, error goes out with the next request
            keep_char(b);
            scan_phase = SCAN_TRAP;
          end else if (cl == CL_DIGIT) begin
            keep_char(b);
          end else begin
            enter_trap();
          end
        end
        SCAN_OPER: begin
          if (cl == CL_BLANK || cl == CL_LETTER || cl == CL_DIGIT) begin
            emit_token(oper_kind());
            restart_lexeme(b);
          end else if (cl == CL_OPER) begin
            keep_char(b);
            if (lex_len > 2) scan_phase = SCAN_TRAP;
          end else begin
            enter_trap();
          end
        end
        SCAN_DELIM: begin
          emit_token(delim_kind());
          restart_lexeme(b);
        end
        SCAN_TRAP: enter_trap();
        default: restart_lexeme(b);
      endcase
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      t.kind = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      pending_tokens.push_back(t);
    end
  endfunction

  function automatic void add_char(logic [7:0] b);
    text_item_t t;
    t.eot = 1'b0;
    t.ch  = b;
    text_queue.push_back(t);
    items_queued++;
  endfunction

  function automatic void add_end(logic [7:0] b);
    text_item_t t;
    t.eot = 1'b1;
    t.ch  = b;
    text_queue.push_back(t);
    items_queued++;
    texts_queued++;
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'(65 + $urandom_range(0, 25));
    return 8'(97 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_oper_char();
    return oper_chars[$urandom_range(0, 7)];
  endfunction

  function automatic void add_lexeme();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_str(kw_list[$urandom_range(0, 7)]);
      if (roll_pct(15)) add_char(rand_letter());
    end else if (pick < 38) begin
      // up to nine characters, past the kept length
      n = $urandom_range(1, 9);
      add_char(rand_letter());
      for (int i = 1; i < n; i++) begin
        add_char(roll_pct(70) ? rand_letter() : num_chars[$urandom_range(0, 9)]);
      end
    end else if (pick < 55) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_char(num_chars[$urandom_range(0, 10)]);
    end else if (pick < 75) begin
      if (roll_pct(80)) begin
        add_str(oper_words[$urandom_range(0, 10)]);
      end else begin
        add_char(rand_oper_char());
        if (roll_pct(60)) add_char(rand_oper_char());
        if (roll_pct(30)) add_char(rand_oper_char());
      end
    end else if (pick < 95) begin
      add_char(delim_chars[$urandom_range(0, 7)]);
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void gen_text();
    int n_lex;
    n_lex = $urandom_range(1, 10);
    for (int i = 0; i < n_lex; i++) begin
      add_lexeme();
      if (roll_pct(85)) begin
        case ($urandom_range(0, 2))
          0:       add_char(8'h20);
          1:       add_char(8'h09);
          default: add_char(8'h0A);
        endcase
      end
    end
    add_end(8'($urandom_range(0, 255)));
  endfunction

  task automatic wait_drained();
    while (text_queue.size() != 0 || in_tvalid || pending_tokens.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // request driver, prediction happens at acceptance
  always @(posedge clk) begin
    text_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      lex_clear();
    end else begin
      if (in_tvalid && in_tready) begin
        lex_step(in_tuser, in_tdata);
        requests_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (text_queue.size() != 0 && !roll_pct(send_idle_pct())) begin
          nxt = text_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.ch;
          in_tuser  <= nxt.eot;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (stall_kick) begin
      stall_left <= HOLD_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // token monitor
  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        tokens_seen++;
        if (out_tdata[5:0] == TK_ACCEPT) n_accept++;
        if (out_tdata[5:0] == TK_REJECT) n_reject++;
        if (out_tdata[5:0] == TK_ERROR) n_error++;
        if (pending_tokens.size() == 0) begin
          $error("token_kind: expected none, got %0d", out_tdata[5:0]);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_tdata[5:0] !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, out_tdata[5:0]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      out_tready <= (!stall_kick && stall_left <= 1) ? !roll_pct(recv_stall_pct()) : 1'b0;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reserved word closed by a delimiter, delimiter pending at end of text
    add_str("if(;");
    add_end(8'h00);
    // letter after number, error goes out with the following blank
    add_str("1a ");
    add_end(8'h5A);
    // third operator char, error still owed at end of text
    add_str("<=<");
    add_end(8'hA5);
    // unknown bytes at both extremes, then absorbed in the trap
    add_char(8'h00);
    add_char(8'hFF);
    add_end(8'hFF);
    // operator closed by a blank, end of text from the start phase
    add_str("!= ");
    add_end(8'h00);
    // number closed by an operator, operator by a letter, word dropped
    add_str("9+b");
    add_end(8'h80);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      int target;
      pace = pace_e'(p);
      target = items_queued + 232;
      while (items_queued < target) gen_text();
      if (pace == PACE_FULL) begin
        stall_kick = 1'b1;
        @(negedge clk);
        stall_kick = 1'b0;
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("sent %0d requests over %0d texts, checked %0d tokens",
             requests_sent, texts_queued, tokens_seen);
    $display("verdicts seen: %0d accept, %0d reject, %0d error tokens",
             n_accept, n_reject, n_error);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d tokens still expected", pending_tokens.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
